// File: rtl/swmm_pkg.sv
// shared types and constants for the sliding window min/max/mean core
package swmm_pkg;

    localparam int SAMPLE_W  = 16;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/swmm_if.sv
// request and result channels of the sliding window min/max/mean core
interface swmm_sample_if;
    logic              valid;
    logic              ready;
    swmm_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swmm_stats_if;
    logic              valid;
    logic              ready;
    swmm_pkg::sample_t window_min;
    swmm_pkg::sample_t window_max;
    swmm_pkg::sample_t window_mean;

    modport source (output valid, output window_min, output window_max,
                    output window_mean, input ready);
    modport sink   (input valid, input window_min, input window_max,
                    input window_mean, output ready);
endinterface

// File: rtl/sliding_window_min_max_mean_core.sv
// sliding window min/max/mean core: ring store, scan sequencer and reciprocal mean
// Each accepted sample request overwrites the oldest of WINDOW ring entries,
// then one adder/compare unit walks the whole ring, one entry per cycle from a
// single read port, and the mean comes from one multiply by a fixed
// reciprocal of WINDOW, exact for every sum the ring can hold. Ready rises
// again once the sequencer has passed the write state, the ring reads, a
// state for the read latency, the multiply state and the state that loads
// the result register. A new sample request is therefore taken only when the
// last one is through, and later when the load waits for a stalled result.
// The result register sits between the sequencer and the output channel, so
// a new sample is taken while a finished result still waits. Entries not yet
// written since reset read as zero through a fill count; there is no clearing
// pass. window_mean is the truncated sum of all WINDOW entries divided by
// WINDOW.
module sliding_window_min_max_mean_core #(
    parameter int WINDOW = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    swmm_sample_if.sink  samples,
    swmm_stats_if.source stats
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int SUM_W = swmm_pkg::SAMPLE_W + AW;

    // reciprocal ceil(2^MEAN_SHIFT / WINDOW): the error stays below one
    // quotient step for any sum below WINDOW * 2^16
    localparam int              MEAN_SHIFT = swmm_pkg::SAMPLE_W + 2 * AW;
    localparam int              RECIP_W    = swmm_pkg::SAMPLE_W + 1 + AW;
    localparam int              PROD_W     = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL  =
        ((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    localparam logic [AW-1:0]      LAST_IDX = AW'(WINDOW - 1);
    localparam logic [FW-1:0]      FULL_CNT = FW'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);

    // sequencer
    swmm_pkg::state_t state_reg, state_next;

    // ring store, no reset: unwritten entries are masked by the fill count
    swmm_pkg::sample_t ring_mem [WINDOW];
    swmm_pkg::sample_t rd_data_reg;
    logic              rd_pend_reg;
    logic              rd_vld_reg;

    logic [AW-1:0]     wpos_reg;
    logic [FW-1:0]     fill_reg;
    logic [AW-1:0]     scan_idx_reg;
    swmm_pkg::sample_t sample_reg;

    // accumulators and mean
    swmm_pkg::sample_t             min_reg;
    swmm_pkg::sample_t             max_reg;
    logic [SUM_W-1:0]              sum_reg;
    swmm_pkg::sample_t             quo_reg;

    // result register
    logic              out_vld_reg;
    swmm_pkg::sample_t out_min_reg;
    swmm_pkg::sample_t out_max_reg;
    swmm_pkg::sample_t out_mean_reg;

    logic              in_fire;
    logic              out_load;
    swmm_pkg::sample_t scan_val;
    logic [PROD_W-1:0] mean_prod;

    assign in_fire   = samples.valid && samples.ready;
    assign scan_val  = rd_vld_reg ? rd_data_reg : '0;
    assign mean_prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};

    // next state and handshake
    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            swmm_pkg::ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = swmm_pkg::ST_WRITE;
                end
            end
            swmm_pkg::ST_WRITE:
            begin
                state_next = swmm_pkg::ST_SCAN;
            end
            swmm_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = swmm_pkg::ST_DRAIN;
                end
            end
            swmm_pkg::ST_DRAIN:
            begin
                state_next = swmm_pkg::ST_DIVIDE;
            end
            swmm_pkg::ST_DIVIDE:
            begin
                state_next = swmm_pkg::ST_FINISH;
            end
            swmm_pkg::ST_FINISH:
            begin
                // hold until the result register is free
                if (!out_vld_reg || stats.ready)
                begin
                    out_load   = 1'b1;
                    state_next = swmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ring write and registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == swmm_pkg::ST_WRITE)
        begin
            ring_mem[wpos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[scan_idx_reg];
    end

    // write position, fill count and read pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= '0;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == swmm_pkg::ST_SCAN);
            // entry is live once written: writes fill slots in order from zero
            rd_vld_reg  <= (FW'(scan_idx_reg) < fill_reg);
            if (state_reg == swmm_pkg::ST_WRITE)
            begin
                wpos_reg     <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + 1'b1;
                scan_idx_reg <= '0;
                if (fill_reg != FULL_CNT)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (state_reg == swmm_pkg::ST_SCAN && scan_idx_reg != LAST_IDX)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // sample latch, accumulation and mean
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= samples.sample;
        end
        if (state_reg == swmm_pkg::ST_WRITE)
        begin
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (scan_val < min_reg)
            begin
                min_reg <= scan_val;
            end
            if (scan_val > max_reg)
            begin
                max_reg <= scan_val;
            end
            sum_reg <= sum_reg + SUM_W'(scan_val);
        end

        if (state_reg == swmm_pkg::ST_DIVIDE)
        begin
            quo_reg <= mean_prod[MEAN_SHIFT +: swmm_pkg::SAMPLE_W];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_min_reg  <= min_reg;
            out_max_reg  <= max_reg;
            out_mean_reg <= quo_reg;
        end
    end

    assign stats.valid       = out_vld_reg;
    assign stats.window_min  = out_min_reg;
    assign stats.window_max  = out_max_reg;
    assign stats.window_mean = out_mean_reg;

    // checks
    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= LAST_IDX)
        else $error("write position beyond window");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond window");

    a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == swmm_pkg::ST_WRITE)
        else $error("accepted sample not written next cycle");

    a_stats_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !stats.ready) |=>
            (out_vld_reg && $stable(out_min_reg) && $stable(out_max_reg)
             && $stable(out_mean_reg)))
        else $error("stalled result changed");

    a_mean_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (quo_reg <= max_reg && min_reg <= max_reg))
        else $error("mean above maximum");

endmodule
